>>> src/y2a_pkg.sv
// y2a_pkg: shared types, BT.601 fixed-point constants and helpers for the
// YUYV to ABGR converter. No dependencies.

package y2a_pkg;

	localparam int FracBits = 10;

	localparam logic [10:0]        LumaGain  = 11'd1192;
	localparam logic [7:0]         LumaBase  = 8'd16;
	localparam logic signed [11:0] CrToR     = 12'sd1634;
	localparam logic signed [10:0] CrToG     = 11'sd833;
	localparam logic signed [9:0]  CbToG     = 10'sd400;
	localparam logic signed [12:0] CbToB     = 13'sd2066;
	localparam logic [7:0]         ChanMax   = 8'd255;
	localparam logic [7:0]         AlphaOpq  = 8'hff;

	typedef logic [18:0]        yterm_t;   // 1192 * (Y - 16), never negative
	typedef logic signed [18:0] crr_t;     // 1634 * (V - 128)
	typedef logic signed [17:0] crg_t;     // 833 * (V - 128)
	typedef logic signed [16:0] cbg_t;     // 400 * (U - 128)
	typedef logic signed [19:0] cbb_t;     // 2066 * (U - 128)
	typedef logic signed [20:0] sum_t;     // channel sum before the shift
	typedef logic signed [7:0]  chroma_t;  // chroma byte minus 128

	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} stage_en_t;

	function automatic chroma_t center(input logic [7:0] c);
		return chroma_t'({~c[7], c[6:0]});
	endfunction

	function automatic logic [7:0] clamp_chan(input sum_t s);
		logic signed [10:0] sh;
		sh = s[20:FracBits];
		if (sh[10]) begin
			return 8'd0;
		end else if (sh[9:8] != 2'b00) begin
			return ChanMax;
		end
		return sh[7:0];
	endfunction

endpackage

>>> src/yuyv_to_abgr_converter.sv
// yuyv_to_abgr_converter: YUYV 4:2:2 quad to two ABGR pixels, BT.601 video
// range. Depends on y2a_pkg and y2a_pixel.
//
//   port group  dir  payload
//   s_*         in   tdata {V, Y1, U, Y0}, tlast = last quad of frame
//   m_*         out  tdata {Y1, Y0, pixel1, pixel0}, tlast = frame end
//
// Three register stages: constant products, channel sums, shift/clamp/pack.
// One quad per cycle sustained while m_tready stays high.
// Stage 3 is the output register; each stage holds while the next is full
// and stalled, so s_tready drops only when all three stages are full.
// Reset clears the stage valid bits only.

module yuyv_to_abgr_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [7:0] luma_first, [15:8] chroma_blue,
	                               // [23:16] luma_second, [31:24] chroma_red
	input  logic        s_tlast,   // last_in_frame
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // [31:0] first_pixel_abgr,
	                               // [63:32] second_pixel_abgr,
	                               // [71:64] first_luma, [79:72] second_luma
	output logic        m_tlast    // frame_end
);
	import y2a_pkg::*;

	logic      v_s1, v_s2, v_s3;
	logic      en_s1;
	stage_en_t en;

	logic [7:0] y0_in, y1_in;
	chroma_t    uc_in, vc_in;

	yterm_t     yterm0_s1, yterm1_s1;
	crr_t       cr_r_s1;
	crg_t       cr_g_s1;
	cbg_t       cb_g_s1;
	cbb_t       cb_b_s1;
	logic [7:0] y0_s1, y1_s1, y0_s2, y1_s2, y0_s3, y1_s3;
	logic       last_s1, last_s2, last_s3;
	logic [31:0] px0, px1;

	assign en.en_s3 = !v_s3 || m_tready;
	assign en.en_s2 = !v_s2 || en.en_s3;
	assign en_s1    = !v_s1 || en.en_s2;
	assign s_tready = en_s1;

	assign y0_in = s_tdata[7:0];
	assign uc_in = center(s_tdata[15:8]);
	assign y1_in = s_tdata[23:16];
	assign vc_in = center(s_tdata[31:24]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en.en_s2) v_s2 <= v_s1;
			if (en.en_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			yterm0_s1 <= (y0_in < LumaBase) ? '0 :
				yterm_t'(LumaGain) * yterm_t'(y0_in - LumaBase);
			yterm1_s1 <= (y1_in < LumaBase) ? '0 :
				yterm_t'(LumaGain) * yterm_t'(y1_in - LumaBase);
			cr_r_s1   <= crr_t'(sum_t'(vc_in) * sum_t'(CrToR));
			cr_g_s1   <= crg_t'(sum_t'(vc_in) * sum_t'(CrToG));
			cb_g_s1   <= cbg_t'(sum_t'(uc_in) * sum_t'(CbToG));
			cb_b_s1   <= cbb_t'(sum_t'(uc_in) * sum_t'(CbToB));
			y0_s1     <= y0_in;
			y1_s1     <= y1_in;
			last_s1   <= s_tlast;
		end
		if (en.en_s2) begin
			y0_s2   <= y0_s1;
			y1_s2   <= y1_s1;
			last_s2 <= last_s1;
		end
		if (en.en_s3) begin
			y0_s3   <= y0_s2;
			y1_s3   <= y1_s2;
			last_s3 <= last_s2;
		end
	end

	y2a_pixel u_px0 (
		.clk   (clk),
		.en    (en),
		.yterm (yterm0_s1),
		.cr_r  (cr_r_s1),
		.cr_g  (cr_g_s1),
		.cb_g  (cb_g_s1),
		.cb_b  (cb_b_s1),
		.abgr  (px0)
	);

	y2a_pixel u_px1 (
		.clk   (clk),
		.en    (en),
		.yterm (yterm1_s1),
		.cr_r  (cr_r_s1),
		.cr_g  (cr_g_s1),
		.cb_g  (cb_g_s1),
		.cb_b  (cb_b_s1),
		.abgr  (px1)
	);

	assign m_tvalid = v_s3;
	assign m_tdata  = {y1_s3, y0_s3, px1, px0};
	assign m_tlast  = last_s3;

	a_ready_when_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s3 || m_tready) |-> s_tready)
		else $error("input stalled while output stage drains");

	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && !m_tready) |-> !s_tready)
		else $error("request taken with full pipeline");

	a_req_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v_s1)
		else $error("accepted request lost at stage 1");

	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !en.en_s2) |=> (v_s2 && $stable(last_s2) && $stable(y0_s2)))
		else $error("stalled stage 2 changed");

endmodule

>>> src/y2a_pixel.sv
// y2a_pixel: stages 2 and 3 of one pixel: channel sums, then floor shift,
// clamp and ABGR packing. Depends on y2a_pkg.

module y2a_pixel (
	input  logic               clk,
	input  y2a_pkg::stage_en_t en,
	input  y2a_pkg::yterm_t    yterm,
	input  y2a_pkg::crr_t      cr_r,
	input  y2a_pkg::crg_t      cr_g,
	input  y2a_pkg::cbg_t      cb_g,
	input  y2a_pkg::cbb_t      cb_b,
	output logic [31:0]        abgr
);
	import y2a_pkg::*;

	sum_t        r_sum_s2, g_sum_s2, b_sum_s2;
	sum_t        y_ext;
	logic [31:0] abgr_s3;

	assign y_ext = sum_t'({2'b00, yterm});

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			r_sum_s2 <= y_ext + sum_t'(cr_r);
			g_sum_s2 <= y_ext - sum_t'(cr_g) - sum_t'(cb_g);
			b_sum_s2 <= y_ext + sum_t'(cb_b);
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			abgr_s3 <= {AlphaOpq, clamp_chan(b_sum_s2), clamp_chan(g_sum_s2),
				clamp_chan(r_sum_s2)};
		end
	end

	assign abgr = abgr_s3;

endmodule
